>>> rtl/smf_pkg.sv
`timescale 1ns / 1ps

package smf_pkg;

    localparam int unsigned VLQ_MAX_BYTES = 4;

    localparam logic [3:0] PH_CHUNK_ID   = 4'd0;
    localparam logic [3:0] PH_SKIP_LEN   = 4'd1;
    localparam logic [3:0] PH_CHUNK_SKIP = 4'd2;
    localparam logic [3:0] PH_TRACK_LEN  = 4'd3;
    localparam logic [3:0] PH_DELTA      = 4'd4;
    localparam logic [3:0] PH_EVENT      = 4'd5;
    localparam logic [3:0] PH_DATA1      = 4'd6;
    localparam logic [3:0] PH_DATA2      = 4'd7;
    localparam logic [3:0] PH_META_TYPE  = 4'd8;
    localparam logic [3:0] PH_EV_LEN     = 4'd9;
    localparam logic [3:0] PH_EV_SKIP    = 4'd10;

    localparam logic [31:0] ID_MTRK       = 32'h4D54_726B;
    localparam logic [7:0]  META_END      = 8'h2F;
    localparam logic [7:0]  BYTE_META     = 8'hFF;
    localparam logic [7:0]  BYTE_SYSEX    = 8'hF0;
    localparam logic [7:0]  BYTE_ESCAPE   = 8'hF7;
    localparam logic [3:0]  STATUS_NOTEON = 4'h9;
    localparam logic [2:0]  STATUS_ONEBYTE = 3'b110;

    typedef struct packed {
        logic       hit;
        logic [6:0] note;
    } t_result;

endpackage

>>> rtl/smf_parser.sv
`timescale 1ns / 1ps

module smf_parser
    import smf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    output t_result    o_result
);

    logic [3:0]  r_phase,   n_phase;
    logic [7:0]  r_status,  n_status;
    logic        r_held,    n_held;
    logic [31:0] r_skip,    n_skip;
    logic [27:0] r_vlq,     n_vlq;
    logic [2:0]  r_idx,     n_idx;
    logic [6:0]  r_key,     n_key;
    logic [7:0]  r_meta,    n_meta;

    logic [2:0]  idx_inc;
    logic [31:0] skip_shift;
    logic [31:0] skip_dec;
    logic [27:0] vlq_shift;
    logic        idx_full;
    logic        one_byte;

    assign idx_inc    = r_idx + 3'd1;
    assign idx_full   = ({29'd0, idx_inc} >= VLQ_MAX_BYTES);
    assign skip_shift = {r_skip[23:0], i_byte};
    assign skip_dec   = r_skip - 32'd1;
    assign vlq_shift  = {r_vlq[20:0], i_byte[6:0]};
    assign one_byte   = (r_status[7:5] == STATUS_ONEBYTE);

    always_comb begin
        n_phase = r_phase;
        n_status = r_status;
        n_held = r_held;
        n_skip = r_skip;
        n_vlq = r_vlq;
        n_idx = r_idx;
        n_key = r_key;
        n_meta = r_meta;
        o_result.hit = 1'b0;
        o_result.note = r_key;
        unique case (r_phase)
            PH_CHUNK_ID: begin
                n_skip = skip_shift;
                n_idx = idx_inc;
                if (idx_inc >= 3'd4) begin
                    n_phase = (skip_shift == ID_MTRK) ? PH_TRACK_LEN : PH_SKIP_LEN;
                    n_skip = 32'd0;
                    n_idx = 3'd0;
                end
            end
            PH_SKIP_LEN, PH_TRACK_LEN: begin
                n_skip = skip_shift;
                n_idx = idx_inc;
                if (idx_inc >= 3'd4) begin
                    n_idx = 3'd0;
                    if (r_phase == PH_TRACK_LEN) begin
                        n_status = 8'd0;
                        n_held = 1'b0;
                        n_skip = 32'd0;
                        n_phase = PH_DELTA;
                    end else if (skip_shift == 32'd0) begin
                        n_phase = PH_CHUNK_ID;
                    end else begin
                        n_phase = PH_CHUNK_SKIP;
                    end
                end
            end
            PH_CHUNK_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == 32'd0) begin
                    n_phase = PH_CHUNK_ID;
                    n_idx = 3'd0;
                end
            end
            PH_DELTA: begin
                n_idx = idx_inc;
                if (!i_byte[7] || idx_full) begin
                    n_phase = PH_EVENT;
                    n_idx = 3'd0;
                end
            end
            PH_EVENT: begin
                priority if (i_byte == BYTE_META) begin
                    n_status = 8'd0;
                    n_held = 1'b0;
                    n_phase = PH_META_TYPE;
                end else if (i_byte == BYTE_SYSEX || i_byte == BYTE_ESCAPE) begin
                    n_status = 8'd0;
                    n_held = 1'b0;
                    n_meta = 8'd0;
                    n_vlq = 28'd0;
                    n_idx = 3'd0;
                    n_phase = PH_EV_LEN;
                end else if (i_byte[7:4] == 4'hF) begin
                    n_status = 8'd0;
                    n_held = 1'b0;
                    n_phase = PH_DELTA;
                    n_idx = 3'd0;
                end else if (i_byte[7]) begin
                    n_status = i_byte;
                    n_held = 1'b1;
                    n_phase = PH_DATA1;
                end else if (r_held) begin
                    n_key = i_byte[6:0];
                    if (one_byte) begin
                        n_phase = PH_DELTA;
                        n_idx = 3'd0;
                    end else begin
                        n_phase = PH_DATA2;
                    end
                end else begin
                    n_phase = PH_DELTA;
                    n_idx = 3'd0;
                end
            end
            PH_DATA1: begin
                n_key = i_byte[6:0];
                if (one_byte) begin
                    n_phase = PH_DELTA;
                    n_idx = 3'd0;
                end else begin
                    n_phase = PH_DATA2;
                end
            end
            PH_DATA2: begin
                n_phase = PH_DELTA;
                n_idx = 3'd0;
                o_result.hit = (r_status[7:4] == STATUS_NOTEON) && !i_byte[7]
                    && (i_byte != 8'd0);
            end
            PH_META_TYPE: begin
                n_meta = i_byte;
                n_vlq = 28'd0;
                n_idx = 3'd0;
                n_phase = PH_EV_LEN;
            end
            PH_EV_LEN: begin
                n_vlq = vlq_shift;
                n_idx = idx_inc;
                if (!i_byte[7] || idx_full) begin
                    n_skip = {4'd0, vlq_shift};
                    n_vlq = 28'd0;
                    n_idx = 3'd0;
                    if (vlq_shift == 28'd0) begin
                        n_phase = (r_meta == META_END) ? PH_CHUNK_ID : PH_DELTA;
                        n_skip = 32'd0;
                        n_meta = 8'd0;
                    end else begin
                        n_phase = PH_EV_SKIP;
                    end
                end
            end
            PH_EV_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == 32'd0) begin
                    n_phase = (r_meta == META_END) ? PH_CHUNK_ID : PH_DELTA;
                    n_idx = 3'd0;
                    n_meta = 8'd0;
                end
            end
            default: begin
                n_phase = PH_CHUNK_ID;
                n_status = 8'd0;
                n_held = 1'b0;
                n_skip = 32'd0;
                n_vlq = 28'd0;
                n_idx = 3'd0;
                n_key = 7'd0;
                n_meta = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CHUNK_ID;
            r_status <= 8'd0;
            r_held <= 1'b0;
            r_skip <= 32'd0;
            r_vlq <= 28'd0;
            r_idx <= 3'd0;
            r_key <= 7'd0;
            r_meta <= 8'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_status <= n_status;
            r_held <= n_held;
            r_skip <= n_skip;
            r_vlq <= n_vlq;
            r_idx <= n_idx;
            r_key <= n_key;
            r_meta <= n_meta;
        end
    end

endmodule

>>> rtl/smf_note_on_extractor.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_data_byte[7:0]
// output    out        o_valid / i_ready    o_note_number[6:0]
//
// One file byte is taken every cycle while o_ready is high; the parser state updates in the same cycle.
// A note-on result is registered into the output entry, or into the skid entry while the output stalls.
// A two-entry output buffer lets input continue while one result waits.
// Input stalls only while both output entries are full.
// Reset is synchronous, active low, and returns to expecting a chunk identifier.

module smf_note_on_extractor
    import smf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [6:0] o_note_number
);

    t_result    parse_res;
    logic       in_fire;
    logic       hit;
    logic       out_free;

    logic       r_out_valid;
    logic [6:0] r_out_note;
    logic       r_skid_valid;
    logic [6:0] r_skid_note;

    assign o_ready = !r_skid_valid;
    assign in_fire = i_valid && o_ready;
    assign hit = in_fire && parse_res.hit;
    assign out_free = !r_out_valid || i_ready;
    assign o_valid = r_out_valid;
    assign o_note_number = r_out_note;

    smf_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (in_fire),
        .i_byte   (i_data_byte),
        .o_result (parse_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid <= 1'b1;
                r_skid_valid <= hit;
            end else begin
                r_out_valid <= hit;
            end
        end else if (hit) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_note <= r_skid_note;
                r_skid_note <= parse_res.note;
            end else begin
                r_out_note <= parse_res.note;
            end
        end else if (hit) begin
            r_skid_note <= parse_res.note;
        end
    end

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("Skid entry holds a result while the output entry is empty.");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_ready))
        else $error("Skid entry filled although the output was not stalled.");

    a_hit_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hit && r_out_valid && !i_ready) |=> r_skid_valid)
        else $error("A result arriving during an output stall was dropped.");

endmodule
